### design/unordered_table_insert_find_remove_top_defines.svh
// Assertion macros for the unordered table block.
// Used by the top level only; relies on clk and rst_n in the including scope.
`ifndef UNORDERED_TABLE_INSERT_FIND_REMOVE_TOP_DEFINES_SVH
`define UNORDERED_TABLE_INSERT_FIND_REMOVE_TOP_DEFINES_SVH

// same-cycle implication
`define UTIFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define UTIFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/utifr_pkg.sv
// Shared types and constants for the unordered table block.
// No dependencies; imported by the controller, datapath and top level.
package utifr_pkg;

  localparam int OP_W    = 2;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int POS_W   = 6;
  localparam int FILL_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_IGNORE = 2'd3
  } utifr_op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_EMPTY     = 2'd3
  } utifr_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_MOVE
  } utifr_state_t;

  typedef struct packed {
    logic [OP_W-1:0]           req_type;
    logic signed [VALUE_W-1:0] value;
  } utifr_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [FILL_W-1:0] fill_count;
  } utifr_res_t;

  // controller -> datapath
  typedef struct packed {
    logic          load;     // capture request, rewind scan
    logic          ins_wr;   // append key, grow count
    logic          scan;     // issue next scan read
    logic          rd_last;  // read the last entry
    logic          move;     // copy last entry into slot, shrink count
    logic          finish;   // register a result
    logic          pos_en;   // result carries the slot
    utifr_status_t status;
  } utifr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    utifr_op_t op;
    logic      full;
    logic      empty;
    logic      hit;
    logic      scan_done;
  } utifr_stat_t;

endpackage

### design/unordered_table_insert_find_remove_top.sv
// Channel   Ports                        Handshake
// request   start, busy, in_req          taken when start is high and busy is low
// result    out_strobe, out_res          one cycle per result, no back-pressure
//
// Insert and unused codes: the result is registered from the check state.
// Find: the scan runs up from slot 0 and stops at the first hit or once every
// entry is compared; remove then adds a read of the last entry and the move.
// The scan reads one entry per cycle through the entry memory's single read port.
// Reset empties the table at once; busy stays high until the result is registered.
// Depends on utifr_pkg, utifr_ctrl, utifr_dp and the defines header.
`include "unordered_table_insert_find_remove_top_defines.svh"

module unordered_table_insert_find_remove_top #(
  parameter int CAPACITY = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  utifr_pkg::utifr_req_t in_req,
  output logic                 out_strobe,
  output utifr_pkg::utifr_res_t out_res
);
  import utifr_pkg::*;

  utifr_cmd_t  cmd;
  utifr_stat_t st;

  utifr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  utifr_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .cmd        (cmd),
    .st         (st),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  `UTIFR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy low after accepted request")
  `UTIFR_ASSERT_NOW(a_strobe_idle, out_strobe, !busy, "result strobed while still busy")
  `UTIFR_ASSERT_NOW(a_err_pos_zero, out_strobe && (out_res.status != STAT_OK), out_res.position == '0, "nonzero position on error")
  `UTIFR_ASSERT_NOW(a_move_nonempty, cmd.move, !st.empty, "move on empty table")

endmodule

### design/utifr_ctrl.sv
// Controller state machine for the unordered table block.
// Depends on utifr_pkg; drives datapath commands from datapath status.
module utifr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  utifr_pkg::utifr_stat_t st,
  output utifr_pkg::utifr_cmd_t  cmd
);
  import utifr_pkg::*;

  utifr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        unique case (st.op)
          OP_FIND, OP_REMOVE: state_nxt = st.empty ? ST_IDLE : ST_SCAN;
          default:            state_nxt = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        priority if (st.hit) begin
          state_nxt = (st.op == OP_REMOVE) ? ST_MOVE : ST_IDLE;
        end else if (st.scan_done) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_MOVE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.status = STAT_OK;
    busy       = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: cmd.load = start;
      ST_CHECK: begin
        unique case (st.op)
          OP_INSERT: begin
            cmd.finish = 1'b1;
            if (st.full) cmd.status = STAT_FULL;
            else         cmd.ins_wr = 1'b1;
          end
          OP_FIND, OP_REMOVE: begin
            if (st.empty) begin
              cmd.finish = 1'b1;
              cmd.status = STAT_EMPTY;
            end else begin
              cmd.scan = 1'b1;
            end
          end
          default: cmd.finish = 1'b1;
        endcase
      end
      ST_SCAN: begin
        priority if (st.hit) begin
          if (st.op == OP_REMOVE) begin
            cmd.rd_last = 1'b1;
          end else begin
            cmd.finish = 1'b1;
            cmd.pos_en = 1'b1;
          end
        end else if (st.scan_done) begin
          cmd.finish = 1'b1;
          cmd.status = STAT_NOT_FOUND;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      ST_MOVE: begin
        cmd.move   = 1'b1;
        cmd.finish = 1'b1;
        cmd.pos_en = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

### design/utifr_dp.sv
// Datapath for the unordered table block: entry memory, count, scan and result register.
// Depends on utifr_pkg; controlled by utifr_ctrl through command and status structs.
module utifr_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  utifr_pkg::utifr_req_t  in_req,
  input  utifr_pkg::utifr_cmd_t  cmd,
  output utifr_pkg::utifr_stat_t st,
  output logic                  out_strobe,
  output utifr_pkg::utifr_res_t  out_res
);
  import utifr_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [VALUE_W-1:0] mem [CAPACITY];

  logic [VALUE_W-1:0] key_r;
  utifr_op_t          op_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   rd_idx_r;
  logic [ADDR_W-1:0]  cmp_idx_r;
  logic               pend_r;
  logic [ADDR_W-1:0]  slot_r, slot_nxt;
  logic [VALUE_W-1:0] rd_data_r;
  logic               out_strobe_r;
  utifr_res_t         res_r;

  logic               issue;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  last_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic               hit;

  assign issue     = cmd.scan && (rd_idx_r < count_r);
  assign last_addr = ADDR_W'(count_r - 1'b1);
  assign rd_en     = issue || cmd.rd_last;
  assign rd_addr   = cmd.rd_last ? last_addr : rd_idx_r[ADDR_W-1:0];
  assign wr_en     = cmd.ins_wr || cmd.move;
  assign wr_addr   = cmd.move ? slot_r : count_r[ADDR_W-1:0];
  assign wr_data   = cmd.move ? rd_data_r : key_r;
  assign hit       = pend_r && (rd_data_r == key_r);
  assign slot_nxt  = hit ? cmp_idx_r : slot_r;

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins_wr)    count_nxt = count_r + 1'b1;
    else if (cmd.move) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      pend_r       <= 1'b0;
      rd_idx_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      pend_r       <= issue;
      out_strobe_r <= cmd.finish;
      if (cmd.load)   rd_idx_r <= '0;
      else if (issue) rd_idx_r <= rd_idx_r + 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_req.value;
      op_r  <= utifr_op_t'(in_req.req_type);
    end
    if (issue) cmp_idx_r <= rd_idx_r[ADDR_W-1:0];
    slot_r <= slot_nxt;
    if (cmd.finish) begin
      res_r.status     <= cmd.status;
      res_r.position   <= cmd.pos_en ? POS_W'(slot_nxt) : '0;
      res_r.fill_count <= FILL_W'(count_nxt);
    end
  end

  always_comb begin
    st.op        = op_r;
    st.full      = (count_r == CNT_W'(CAPACITY));
    st.empty     = (count_r == '0);
    st.hit       = hit;
    st.scan_done = !pend_r && (rd_idx_r >= count_r);
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = res_r;

endmodule

### dv/utifr_checker.sv
// Scoreboard for the unordered table block: watches the request and result
// channels, predicts every result and compares it field by field.
// Depends on utifr_pkg only.
module utifr_checker #(
  parameter int CAPACITY = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  utifr_pkg::utifr_req_t in_req,
  input  logic                  out_strobe,
  input  utifr_pkg::utifr_res_t out_res,
  output int                    err_cnt,
  output int                    pending,
  output int                    checked_cnt,
  output int                    full_cnt,
  output int                    miss_cnt,
  output int                    empty_cnt
);
  import utifr_pkg::*;

  logic [VALUE_W-1:0] table_entries [CAPACITY];
  int                 table_fill = 0;
  utifr_res_t         expected_q [$];
  int                 errs = 0;
  int                 checked = 0;
  int                 fulls = 0;
  int                 misses = 0;
  int                 empties = 0;

  // Apply one request to the shadow table and return the result it must give.
  function automatic utifr_res_t apply_request(utifr_req_t req);
    utifr_res_t res;
    int         slot;
    res  = '0;
    slot = -1;
    res.status = STAT_OK;
    case (utifr_op_t'(req.req_type))
      OP_INSERT: begin
        if (table_fill >= CAPACITY) begin
          res.status = STAT_FULL;
        end else begin
          table_entries[table_fill] = req.value;
          table_fill++;
        end
      end
      OP_FIND, OP_REMOVE: begin
        if (table_fill == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          // lowest matching slot wins
          for (int i = 0; i < table_fill && slot < 0; i++) begin
            if (table_entries[i] == req.value) slot = i;
          end
          if (slot < 0) begin
            res.status = STAT_NOT_FOUND;
          end else begin
            res.position = slot[POS_W-1:0];
            if (utifr_op_t'(req.req_type) == OP_REMOVE) begin
              // swap the last entry into the hole, then shrink
              table_entries[slot] = table_entries[table_fill-1];
              table_fill--;
            end
          end
        end
      end
      default: ;
    endcase
    res.fill_count = table_fill[FILL_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    utifr_res_t want;
    if (!rst_n) begin
      table_fill = 0;
      expected_q.delete();
    end else begin
      // compare before predicting: a result never belongs to a request taken at the same edge
      if (out_strobe) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: status %0d position %0d fill_count %0d",
                 out_res.status, out_res.position, out_res.fill_count);
          errs++;
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (out_res.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_res.status);
            errs++;
          end
          if (out_res.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_res.position);
            errs++;
          end
          if (out_res.fill_count !== want.fill_count) begin
            $error("fill_count: expected %0d, got %0d", want.fill_count, out_res.fill_count);
            errs++;
          end
          case (utifr_status_t'(want.status))
            STAT_FULL:      fulls++;
            STAT_NOT_FOUND: misses++;
            STAT_EMPTY:     empties++;
            default: ;
          endcase
        end
      end
      if (start && !busy) expected_q.push_back(apply_request(in_req));
    end
    err_cnt     <= errs;
    pending     <= expected_q.size();
    checked_cnt <= checked;
    full_cnt    <= fulls;
    miss_cnt    <= misses;
    empty_cnt   <= empties;
  end

endmodule

### dv/tb_top.sv
// Top of the unordered table testbench: clock, reset, request stimulus and verdict.
// Depends on utifr_pkg, the unordered_table_insert_find_remove_top block and utifr_checker.
module tb_top;
  import utifr_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int RANDOM_ITEMS = 1100;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int TAIL_CYCLES  = CAPACITY + 8;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  utifr_req_t in_req = '0;
  logic       out_strobe;
  utifr_res_t out_res;

  int err_cnt, pending, checked_cnt, full_cnt, miss_cnt, empty_cnt;
  int cycle_cnt = 0;
  int sent = 0;
  bit no_idle = 1'b0;

  logic [VALUE_W-1:0] value_pool [12];
  logic [VALUE_W-1:0] recent_vals [16];
  int                 recent_wr = 0;

  unordered_table_insert_find_remove_top #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_res   (out_res)
  );

  utifr_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res),
    .err_cnt    (err_cnt),
    .pending    (pending),
    .checked_cnt(checked_cnt),
    .full_cnt   (full_cnt),
    .miss_cnt   (miss_cnt),
    .empty_cnt  (empty_cnt)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("unordered_table_insert_find_remove_top verification failed");
    $finish;
  end

  // Hold start high with the request until the block takes it.
  task automatic send_request(input utifr_op_t op, input logic [VALUE_W-1:0] v);
    int gap;
    int r;
    gap = 0;
    if (!no_idle) begin
      r = $urandom_range(0, 99);
      if (r < 60) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= '{req_type: op, value: v};
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // Drop start and hold off until every outstanding result has come back.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    utifr_op_t          op;
    logic [VALUE_W-1:0] v;
    int                 r;
    int                 ins_w;
    int                 find_w;
    int                 round_len;
    int                 round;
    int                 random_sent;

    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    value_pool[4] = 32'h0000_0001;
    for (int i = 5; i < 12; i++) value_pool[i] = $urandom();
    for (int i = 0; i < 16; i++) recent_vals[i] = $urandom();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, duplicates, swap-in, self-move, misses
    send_request(OP_FIND, 32'h0000_0000);
    send_request(OP_REMOVE, 32'h0000_0005);
    send_request(OP_IGNORE, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h8000_0000);
    send_request(OP_INSERT, 32'h7FFF_FFFF);
    send_request(OP_INSERT, 32'h0000_0000);
    send_request(OP_INSERT, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h8000_0000);
    send_request(OP_FIND, 32'h8000_0000);
    send_request(OP_FIND, 32'hFFFF_FFFF);
    send_request(OP_FIND, 32'h0000_3039);
    send_request(OP_IGNORE, 32'h0000_0000);
    send_request(OP_REMOVE, 32'h7FFF_FFFF);
    send_request(OP_FIND, 32'h8000_0000);
    send_request(OP_REMOVE, 32'hFFFF_FFFF);
    send_request(OP_REMOVE, 32'h0000_0063);
    send_request(OP_REMOVE, 32'h8000_0000);
    send_request(OP_REMOVE, 32'h8000_0000);
    send_request(OP_FIND, 32'h0000_0000);
    send_request(OP_REMOVE, 32'h0000_0000);
    send_request(OP_FIND, 32'h0000_0000);
    wait_idle();

    // random rounds cycle through fill, mixed, drain and mixed mixes
    round = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case (round % 4)
        0: begin ins_w = 80; find_w = 10; round_len = $urandom_range(120, 160); end
        2: begin ins_w = 15; find_w = 20; round_len = $urandom_range(80, 140); end
        default: begin ins_w = 40; find_w = 30; round_len = $urandom_range(60, 120); end
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (round_len) begin
        r = $urandom_range(0, 99);
        if (r < ins_w) op = OP_INSERT;
        else if (r < ins_w + find_w) op = OP_FIND;
        else if (r < 98) op = OP_REMOVE;
        else op = OP_IGNORE;
        r = $urandom_range(0, 9);
        if (r < 6) begin
          v = value_pool[$urandom_range(0, 11)];
        end else if (r < 8) begin
          v = recent_vals[$urandom_range(0, 15)];
        end else begin
          v = $urandom();
          // remember fresh inserts so later finds and removes can hit them
          if (op == OP_INSERT) begin
            recent_vals[recent_wr] = v;
            recent_wr = (recent_wr + 1) % 16;
          end
        end
        send_request(op, v);
        random_sent++;
      end
      wait_idle();
      round++;
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d requests and checked %0d results over %0d random rounds.",
             sent, checked_cnt, round);
    $display("Saw %0d inserts into a full table, %0d misses and %0d requests on an empty table.",
             full_cnt, miss_cnt, empty_cnt);
    if (err_cnt == 0) begin
      $display("unordered_table_insert_find_remove_top verification clean");
    end else begin
      $display("unordered_table_insert_find_remove_top verification failed");
    end
    $finish;
  end

endmodule
